// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the display blanking controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dbc_pkg.sv =====
// ----------------------------------------------------------------------------
// dbc_pkg
// Types and constants shared by the display blanking controller modules.
// ----------------------------------------------------------------------------
package dbc_pkg;

    localparam int unsigned NUM_OUTPUTS = 5;
    localparam int unsigned NOW_W       = 32;
    localparam int unsigned DIV_W       = 16;
    localparam int unsigned DIV_Q_W     = 32;
    localparam int unsigned STEP_W      = 5;
    localparam int unsigned PROG_W      = 16;
    localparam int unsigned TMO_MS_W    = 26;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // Whole seconds of elapsed time fit in 23 bits; progress needs 16 quotient bits.
    localparam logic [STEP_W-1:0] STEPS_SECONDS  = 5'd23;
    localparam logic [STEP_W-1:0] STEPS_PROGRESS = 5'd16;

    localparam logic [DIV_W-1:0]  MS_PER_S       = 16'd1000;
    localparam logic [DIV_W-1:0]  TIMEOUT_RESET  = 16'd300;
    localparam logic [PROG_W-1:0] PROGRESS_MAX   = 16'hFFFF;

    localparam logic [2:0] DOW_SUNDAY   = 3'd1;
    localparam logic [2:0] DOW_SATURDAY = 3'd7;

    typedef logic [1:0] action_t;
    localparam action_t ACT_NORMAL   = 2'd0;
    localparam action_t ACT_DIM      = 2'd1;
    localparam action_t ACT_BLANK    = 2'd2;
    localparam action_t ACT_RESERVED = 2'd3;

    localparam int unsigned ACT_IDX_LEDS = 1;

    localparam logic [3:0] DAY_NEVER         = 4'd0;
    localparam logic [3:0] DAY_HOURS         = 4'd1;
    localparam logic [3:0] DAY_WEEKEND       = 4'd2;
    localparam logic [3:0] DAY_WKEND_OR_HRS  = 4'd3;
    localparam logic [3:0] DAY_WKEND_AND_HRS = 4'd4;
    localparam logic [3:0] DAY_WEEKDAY       = 4'd5;
    localparam logic [3:0] DAY_WKDAY_OR_HRS  = 4'd6;
    localparam logic [3:0] DAY_WKDAY_AND_HRS = 4'd7;
    localparam logic [3:0] DAY_ALWAYS        = 4'd8;

    localparam logic [1:0] MM_TIME_ONLY      = 2'd0;
    localparam logic [1:0] MM_TIME_OR_MOTION = 2'd1;
    localparam logic [1:0] MM_SENSOR_WINS    = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_DAY_MODE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOUR_START     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOUR_END       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTION_TIMEOUT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTION_MODE    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_ACTIONS = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV_SEC,
        ST_NUMER,
        ST_CHECK,
        ST_DIV_PROG,
        ST_STORE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                start;
        logic [STEP_W-1:0]   steps;
        logic [DIV_W-1:0]    divisor;
        logic [DIV_W-1:0]    rem_init;
        logic [DIV_Q_W-1:0]  quo_init;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic last;
    } div_stat_t;

    typedef struct packed {
        logic [3:0]                     day_mode;
        logic [4:0]                     hour_start;
        logic [4:0]                     hour_end;
        logic [1:0]                     motion_mode;
        action_t [NUM_OUTPUTS-1:0]      output_actions;
        logic [2:0]                     day_of_week;
        logic [4:0]                     hour_of_day;
        logic                           led_override;
        logic                           motion_blank;
        logic                           sensor_seen;
        action_t [NUM_OUTPUTS-1:0]      previous;
    } decide_in_t;

    typedef struct packed {
        logic                           blanked;
        logic                           time_blank;
        action_t [NUM_OUTPUTS-1:0]      actions;
        logic [NUM_OUTPUTS-1:0]         changed_mask;
    } decide_out_t;

endpackage

// ===== rtl/dbc_if.sv =====
// ----------------------------------------------------------------------------
// dbc_if
// Update and result channels of the display blanking controller.
// ----------------------------------------------------------------------------
interface dbc_in_if;
    logic        valid;
    logic        ready;
    logic        motion_level;
    logic [31:0] now_ms;
    logic [2:0]  day_of_week;
    logic [4:0]  hour_of_day;
    logic        led_override;

    modport source (output valid, motion_level, now_ms, day_of_week, hour_of_day,
                    led_override, input ready);
    modport sink   (input valid, motion_level, now_ms, day_of_week, hour_of_day,
                    led_override, output ready);
endinterface

interface dbc_out_if;
    logic        valid;
    logic        ready;
    logic        blanked;
    logic        time_blank;
    logic        motion_blank;
    logic        sensor_present;
    logic [1:0]  tubes_action;
    logic [1:0]  leds_action;
    logic [1:0]  neons_action;
    logic [1:0]  slave_action;
    logic [1:0]  towers_action;
    logic [4:0]  changed_mask;
    logic [15:0] progress_permille;

    modport source (output valid, blanked, time_blank, motion_blank, sensor_present,
                    tubes_action, leds_action, neons_action, slave_action,
                    towers_action, changed_mask, progress_permille, input ready);
    modport sink   (input valid, blanked, time_blank, motion_blank, sensor_present,
                    tubes_action, leds_action, neons_action, slave_action,
                    towers_action, changed_mask, progress_permille, output ready);
endinterface

// ===== rtl/dbc_serial_div.sv =====
// ----------------------------------------------------------------------------
// dbc_serial_div
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module dbc_serial_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dbc_pkg::div_ctrl_t                ctrl,
    output dbc_pkg::div_stat_t                stat,
    output logic [dbc_pkg::DIV_Q_W-1:0]       quotient,
    output logic [dbc_pkg::DIV_W-1:0]         remainder
);

    logic [dbc_pkg::DIV_W-1:0]   rem_reg, rem_next;
    logic [dbc_pkg::DIV_W-1:0]   dsr_reg, dsr_next;
    logic [dbc_pkg::DIV_Q_W-1:0] quo_reg, quo_next;
    logic [dbc_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic [dbc_pkg::DIV_W:0]     trial;
    logic [dbc_pkg::DIV_W:0]     diff;
    logic                        fits;

    // The dividend shifts out of the top of the quotient register while
    // quotient bits enter at the bottom.
    assign trial = {rem_reg, quo_reg[dbc_pkg::DIV_Q_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctrl.start)
        begin
            rem_next  = ctrl.rem_init;
            dsr_next  = ctrl.divisor;
            quo_next  = ctrl.quo_init;
            cnt_next  = ctrl.steps;
            busy_next = (ctrl.steps != '0);
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[dbc_pkg::DIV_W-1:0] : trial[dbc_pkg::DIV_W-1:0];
            quo_next  = {quo_reg[dbc_pkg::DIV_Q_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != {{(dbc_pkg::STEP_W-1){1'b0}}, 1'b1});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.last = busy_reg && (cnt_reg == {{(dbc_pkg::STEP_W-1){1'b0}}, 1'b1});
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/dbc_decide.sv =====
// ----------------------------------------------------------------------------
// dbc_decide
// Time window, blank combination, per-output action selection and change mask.
// ----------------------------------------------------------------------------
module dbc_decide (
    input  dbc_pkg::decide_in_t  din,
    output dbc_pkg::decide_out_t dout
);

    logic wkend;
    logic wkday;
    logic hrs;
    logic tblank;
    logic blank;
    dbc_pkg::action_t [dbc_pkg::NUM_OUTPUTS-1:0] act;

    always_comb
    begin
        wkend = (din.day_of_week == dbc_pkg::DOW_SUNDAY) ||
                (din.day_of_week == dbc_pkg::DOW_SATURDAY);
        wkday = (din.day_of_week > dbc_pkg::DOW_SUNDAY) &&
                (din.day_of_week < dbc_pkg::DOW_SATURDAY);

        // A window whose start lies after its end runs past midnight.
        if (din.hour_start > din.hour_end)
            hrs = (din.hour_of_day >= din.hour_start) || (din.hour_of_day < din.hour_end);
        else if (din.hour_start < din.hour_end)
            hrs = (din.hour_of_day >= din.hour_start) && (din.hour_of_day < din.hour_end);
        else
            hrs = (din.hour_of_day == din.hour_start);

        case (din.day_mode)
            dbc_pkg::DAY_HOURS:         tblank = hrs;
            dbc_pkg::DAY_WEEKEND:       tblank = wkend;
            dbc_pkg::DAY_WKEND_OR_HRS:  tblank = wkend || hrs;
            dbc_pkg::DAY_WKEND_AND_HRS: tblank = wkend && hrs;
            dbc_pkg::DAY_WEEKDAY:       tblank = wkday;
            dbc_pkg::DAY_WKDAY_OR_HRS:  tblank = wkday || hrs;
            dbc_pkg::DAY_WKDAY_AND_HRS: tblank = wkday && hrs;
            dbc_pkg::DAY_ALWAYS:        tblank = 1'b1;
            default:                    tblank = 1'b0;
        endcase

        case (din.motion_mode)
            dbc_pkg::MM_TIME_ONLY:      blank = tblank;
            dbc_pkg::MM_TIME_OR_MOTION: blank = tblank || din.motion_blank;
            default:                    blank = din.sensor_seen ? din.motion_blank : tblank;
        endcase

        for (int i = 0; i < dbc_pkg::NUM_OUTPUTS; i++)
        begin
            if (!blank)
                act[i] = dbc_pkg::ACT_NORMAL;
            else if (din.output_actions[i] == dbc_pkg::ACT_RESERVED)
                act[i] = dbc_pkg::ACT_BLANK;
            else
                act[i] = din.output_actions[i];
        end
        if (din.led_override)
            act[dbc_pkg::ACT_IDX_LEDS] = dbc_pkg::ACT_BLANK;

        for (int i = 0; i < dbc_pkg::NUM_OUTPUTS; i++)
            dout.changed_mask[i] = (act[i] != din.previous[i]);

        dout.blanked    = blank;
        dout.time_blank = tblank;
        dout.actions    = act;
    end

endmodule

// ===== rtl/display_blanking_controller.sv =====
// ----------------------------------------------------------------------------
// display_blanking_controller
// Blanking decision and per-output actions from motion, time and day.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  --------  ---------  ------------------------------------------------------
//  in_ch     sink       one update beat: motion, time in ms, weekday, hour,
//                       LED override
//  out_ch    source     one result beat per update: decisions, five actions,
//                       change mask, per-mille progress
//  cfg_*     write      register index, data and write enable
//
//  An update with motion present passes through the load and finish states
//  to the result register; without motion the shared bit-serial divider runs
//  once for the whole seconds elapsed and, unless progress is zero or
//  saturated, once more for the progress, before the finish state.
//  Reset is asynchronous and active low. A result beat may wait in the result
//  register while the next update is taken; a stalled output then holds the
//  controller in its final state.
//
`include "assert_macros.svh"

module display_blanking_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    dbc_in_if.sink                              in_ch,
    dbc_out_if.source                           out_ch,
    input  logic                                cfg_we,
    input  logic [dbc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dbc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Configuration registers.
    logic [3:0]                   day_mode_reg;
    logic [4:0]                   hour_start_reg;
    logic [4:0]                   hour_end_reg;
    logic [dbc_pkg::DIV_W-1:0]    timeout_reg;
    logic [1:0]                   motion_mode_reg;
    logic [9:0]                   out_actions_reg;

    // Timeout in milliseconds, formed as 1024t - 16t - 8t and kept registered.
    logic [dbc_pkg::TMO_MS_W-1:0] tmo_ms_reg;
    logic [dbc_pkg::TMO_MS_W-1:0] tmo_ms_next;

    // Captured update and working values.
    logic                         motion_reg;
    logic [2:0]                   dow_reg;
    logic [4:0]                   hour_reg;
    logic                         led_reg;
    logic [dbc_pkg::NOW_W-1:0]    el_ms_reg;
    logic [dbc_pkg::NOW_W-1:0]    numer_reg, numer_next;
    logic [dbc_pkg::PROG_W-1:0]   progress_reg, progress_next;
    logic                         mblank_reg, mblank_next;

    // Block state kept across updates.
    logic [dbc_pkg::NOW_W-1:0]    last_motion_reg;
    logic                         sensor_seen_reg;
    dbc_pkg::action_t [dbc_pkg::NUM_OUTPUTS-1:0] prev_act_reg;

    dbc_pkg::state_t              state_reg, state_next;

    // Result register.
    logic                         out_valid_reg, out_valid_next;
    dbc_pkg::decide_out_t         result_reg;
    logic                         res_mblank_reg;
    logic                         res_sensor_reg;
    logic [dbc_pkg::PROG_W-1:0]   res_progress_reg;

    logic                         in_accept;
    logic                         out_load;
    dbc_pkg::div_ctrl_t           div_ctrl;
    dbc_pkg::div_stat_t           div_stat;
    logic [dbc_pkg::DIV_Q_W-1:0]  div_quo;
    logic [dbc_pkg::DIV_W-1:0]    div_rem;
    dbc_pkg::decide_in_t          dec_in;
    dbc_pkg::decide_out_t         dec_out;

    assign in_accept = in_ch.valid && in_ch.ready;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_mode_reg    <= dbc_pkg::DAY_NEVER;
            hour_start_reg  <= '0;
            hour_end_reg    <= '0;
            timeout_reg     <= dbc_pkg::TIMEOUT_RESET;
            motion_mode_reg <= dbc_pkg::MM_TIME_ONLY;
            out_actions_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dbc_pkg::CFG_DAY_MODE:       day_mode_reg    <= cfg_data[3:0];
                dbc_pkg::CFG_HOUR_START:     hour_start_reg  <= cfg_data[4:0];
                dbc_pkg::CFG_HOUR_END:       hour_end_reg    <= cfg_data[4:0];
                dbc_pkg::CFG_MOTION_TIMEOUT: timeout_reg     <= cfg_data;
                dbc_pkg::CFG_MOTION_MODE:    motion_mode_reg <= cfg_data[1:0];
                dbc_pkg::CFG_OUTPUT_ACTIONS: out_actions_reg <= cfg_data[9:0];
                default:                     ;
            endcase
        end
    end

    // The user must make configuration changes only while idle; the block
    // does not enforce it. The comparison reads this value registered.
    assign tmo_ms_next = {timeout_reg, 10'b0}
                       - {6'b0, timeout_reg, 4'b0}
                       - {7'b0, timeout_reg, 3'b0};

    always_ff @(posedge clk)
    begin
        tmo_ms_reg <= tmo_ms_next;
    end

    // ------------------------------------------------------------------
    // Shared bit-serial divider
    // ------------------------------------------------------------------
    dbc_serial_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dbc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        in_ch.ready      = 1'b0;
        out_load         = 1'b0;
        numer_next       = numer_reg;
        progress_next    = progress_reg;
        mblank_next      = mblank_reg;
        div_ctrl.start   = 1'b0;
        div_ctrl.steps   = dbc_pkg::STEPS_SECONDS;
        div_ctrl.divisor = dbc_pkg::MS_PER_S;
        div_ctrl.rem_init = {7'b0, el_ms_reg[31:23]};
        div_ctrl.quo_init = {el_ms_reg[22:0], 9'b0};

        case (state_reg)
            dbc_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    progress_next = '0;
                    state_next    = dbc_pkg::ST_LOAD;
                end
            end

            dbc_pkg::ST_LOAD:
            begin
                if (motion_reg)
                begin
                    mblank_next = 1'b0;
                    state_next  = dbc_pkg::ST_FINISH;
                end
                else
                begin
                    // The timeout in ms never reaches 2^26, so it cannot wrap.
                    mblank_next    = (el_ms_reg > {6'b0, tmo_ms_reg});
                    div_ctrl.start = 1'b1;
                    state_next     = dbc_pkg::ST_DIV_SEC;
                end
            end

            dbc_pkg::ST_DIV_SEC:
            begin
                if (div_stat.last)
                    state_next = dbc_pkg::ST_NUMER;
            end

            dbc_pkg::ST_NUMER:
            begin
                // Whole seconds times 1000 is the elapsed time less the remainder.
                numer_next = el_ms_reg - {16'b0, div_rem};
                state_next = dbc_pkg::ST_CHECK;
            end

            dbc_pkg::ST_CHECK:
            begin
                if (numer_reg == '0)
                begin
                    progress_next = '0;
                    state_next    = dbc_pkg::ST_FINISH;
                end
                else if (numer_reg[31:16] >= timeout_reg)
                begin
                    // Quotient would not fit in 16 bits; a zero timeout lands here too.
                    progress_next = dbc_pkg::PROGRESS_MAX;
                    state_next    = dbc_pkg::ST_FINISH;
                end
                else
                begin
                    div_ctrl.start    = 1'b1;
                    div_ctrl.steps    = dbc_pkg::STEPS_PROGRESS;
                    div_ctrl.divisor  = timeout_reg;
                    div_ctrl.rem_init = numer_reg[31:16];
                    div_ctrl.quo_init = {numer_reg[15:0], 16'b0};
                    state_next        = dbc_pkg::ST_DIV_PROG;
                end
            end

            dbc_pkg::ST_DIV_PROG:
            begin
                if (div_stat.last)
                    state_next = dbc_pkg::ST_STORE;
            end

            dbc_pkg::ST_STORE:
            begin
                progress_next = div_quo[dbc_pkg::PROG_W-1:0];
                state_next    = dbc_pkg::ST_FINISH;
            end

            dbc_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = dbc_pkg::ST_IDLE;
                end
            end

            default:
                state_next = dbc_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Update capture and motion tracking
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_motion_reg <= '0;
            sensor_seen_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            if (in_ch.motion_level)
                last_motion_reg <= in_ch.now_ms;
            else
                sensor_seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            motion_reg <= in_ch.motion_level;
            dow_reg    <= in_ch.day_of_week;
            hour_reg   <= in_ch.hour_of_day;
            led_reg    <= in_ch.led_override;
            // Modulo 2^32 difference, so a wrapped clock still gives the right age.
            el_ms_reg  <= in_ch.now_ms - last_motion_reg;
        end
        numer_reg    <= numer_next;
        progress_reg <= progress_next;
        mblank_reg   <= mblank_next;
    end

    // ------------------------------------------------------------------
    // Decision and actions
    // ------------------------------------------------------------------
    always_comb
    begin
        dec_in.day_mode       = day_mode_reg;
        dec_in.hour_start     = hour_start_reg;
        dec_in.hour_end       = hour_end_reg;
        dec_in.motion_mode    = motion_mode_reg;
        dec_in.output_actions = out_actions_reg;
        dec_in.day_of_week    = dow_reg;
        dec_in.hour_of_day    = hour_reg;
        dec_in.led_override   = led_reg;
        dec_in.motion_blank   = mblank_reg;
        dec_in.sensor_seen    = sensor_seen_reg;
        dec_in.previous       = prev_act_reg;
    end

    dbc_decide u_decide (
        .din  (dec_in),
        .dout (dec_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_act_reg <= '0;
        else if (out_load)
            prev_act_reg <= dec_out.actions;
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg       <= dec_out;
            res_mblank_reg   <= mblank_reg;
            res_sensor_reg   <= sensor_seen_reg;
            res_progress_reg <= progress_reg;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.blanked           = result_reg.blanked;
    assign out_ch.time_blank        = result_reg.time_blank;
    assign out_ch.motion_blank      = res_mblank_reg;
    assign out_ch.sensor_present    = res_sensor_reg;
    assign out_ch.tubes_action      = result_reg.actions[0];
    assign out_ch.leds_action       = result_reg.actions[1];
    assign out_ch.neons_action      = result_reg.actions[2];
    assign out_ch.slave_action      = result_reg.actions[3];
    assign out_ch.towers_action     = result_reg.actions[4];
    assign out_ch.changed_mask      = result_reg.changed_mask;
    assign out_ch.progress_permille = res_progress_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_div_quiet_when_idle, clk, rst_n, in_ch.ready, !div_stat.busy, "divider busy while accepting an update")
    `ASSERT_NEXT(a_motion_stamp, clk, rst_n, in_accept && in_ch.motion_level, last_motion_reg == $past(in_ch.now_ms), "motion time not recorded")
    `ASSERT_IMPL(a_motion_no_progress, clk, rst_n, out_load && motion_reg, !mblank_reg && (progress_reg == '0), "motion update gave timeout state")

endmodule

// ===== dv/display_blanking_controller_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// display_blanking_controller_tb
// Self-checking bench for the display blanking controller. Update beats are
// offered with random gaps and result beats are taken with random stalls. A
// scoreboard keeps its own copy of the registers and of the motion and action
// state, predicts each result and compares every field in order.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic        motion_level;
    logic [31:0] now_ms;
    logic [2:0]  day_of_week;
    logic [4:0]  hour_of_day;
    logic        led_override;
} update_t;

typedef struct packed {
    logic                                        blanked;
    logic                                        time_blank;
    logic                                        motion_blank;
    logic                                        sensor_present;
    dbc_pkg::action_t [dbc_pkg::NUM_OUTPUTS-1:0] actions;
    logic [dbc_pkg::NUM_OUTPUTS-1:0]             changed_mask;
    logic [dbc_pkg::PROG_W-1:0]                  progress_permille;
} result_t;

typedef struct packed {
    logic [3:0]  day_mode;
    logic [4:0]  hour_start;
    logic [4:0]  hour_end;
    logic [15:0] motion_timeout_s;
    logic [1:0]  motion_mode;
    logic [9:0]  output_actions;
} blank_cfg_t;

class blank_scoreboard;
    blank_cfg_t cfg;
    logic [31:0] last_motion_ms;
    logic sensor_seen;
    dbc_pkg::action_t prev_actions [dbc_pkg::NUM_OUTPUTS];
    result_t expected_q [$];
    int mismatches;
    int updates_noted;
    int results_checked;
    int n_blanked;
    int n_motion_blank;
    int n_saturated;
    int n_changes;

    function new();
        cfg = '0;
        cfg.motion_timeout_s = dbc_pkg::TIMEOUT_RESET;
        last_motion_ms = '0;
        sensor_seen = 1'b0;
        foreach (prev_actions[i])
            prev_actions[i] = dbc_pkg::ACT_NORMAL;
        mismatches = 0;
        updates_noted = 0;
        results_checked = 0;
        n_blanked = 0;
        n_motion_blank = 0;
        n_saturated = 0;
        n_changes = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void write_reg(logic [dbc_pkg::CFG_INDEX_W-1:0] idx,
                            logic [dbc_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            dbc_pkg::CFG_DAY_MODE:       cfg.day_mode = data[3:0];
            dbc_pkg::CFG_HOUR_START:     cfg.hour_start = data[4:0];
            dbc_pkg::CFG_HOUR_END:       cfg.hour_end = data[4:0];
            dbc_pkg::CFG_MOTION_TIMEOUT: cfg.motion_timeout_s = data[15:0];
            dbc_pkg::CFG_MOTION_MODE:    cfg.motion_mode = data[1:0];
            dbc_pkg::CFG_OUTPUT_ACTIONS: cfg.output_actions = data[9:0];
            default: ;
        endcase
    endfunction

    // Works out the result of one accepted update and queues it.
    function void note_update(update_t u);
        logic [31:0] elapsed_ms;
        logic [31:0] elapsed_s;
        logic [31:0] timeout_ms;
        logic [63:0] ratio;
        logic in_window;
        logic weekend;
        logic weekday;
        logic t_blank;
        logic m_blank;
        logic blank;
        logic [dbc_pkg::PROG_W-1:0] progress;
        dbc_pkg::action_t act;
        result_t r;

        updates_noted++;
        m_blank = 1'b0;
        progress = '0;
        if (u.motion_level)
        begin
            last_motion_ms = u.now_ms;
        end
        else
        begin
            // Elapsed time is taken modulo 2^32 so a wrap of the clock is harmless.
            elapsed_ms = u.now_ms - last_motion_ms;
            elapsed_s = elapsed_ms / dbc_pkg::MS_PER_S;
            timeout_ms = 32'(cfg.motion_timeout_s);
            timeout_ms = timeout_ms * 32'd1000;
            sensor_seen = 1'b1;
            if (elapsed_s != 0)
            begin
                if (cfg.motion_timeout_s == 0)
                begin
                    progress = dbc_pkg::PROGRESS_MAX;
                end
                else
                begin
                    ratio = 64'(elapsed_s);
                    ratio = (ratio * 64'd1000) / 64'(cfg.motion_timeout_s);
                    progress = (ratio > 64'(dbc_pkg::PROGRESS_MAX)) ? dbc_pkg::PROGRESS_MAX
                                                                    : ratio[15:0];
                end
            end
            m_blank = elapsed_ms > timeout_ms;
        end

        if (cfg.hour_start > cfg.hour_end)
            in_window = (u.hour_of_day >= cfg.hour_start) || (u.hour_of_day < cfg.hour_end);
        else if (cfg.hour_start < cfg.hour_end)
            in_window = (u.hour_of_day >= cfg.hour_start) && (u.hour_of_day < cfg.hour_end);
        else
            in_window = u.hour_of_day == cfg.hour_start;

        weekend = (u.day_of_week == dbc_pkg::DOW_SUNDAY) ||
                  (u.day_of_week == dbc_pkg::DOW_SATURDAY);
        weekday = (u.day_of_week > dbc_pkg::DOW_SUNDAY) &&
                  (u.day_of_week < dbc_pkg::DOW_SATURDAY);

        case (cfg.day_mode)
            dbc_pkg::DAY_HOURS:         t_blank = in_window;
            dbc_pkg::DAY_WEEKEND:       t_blank = weekend;
            dbc_pkg::DAY_WKEND_OR_HRS:  t_blank = weekend || in_window;
            dbc_pkg::DAY_WKEND_AND_HRS: t_blank = weekend && in_window;
            dbc_pkg::DAY_WEEKDAY:       t_blank = weekday;
            dbc_pkg::DAY_WKDAY_OR_HRS:  t_blank = weekday || in_window;
            dbc_pkg::DAY_WKDAY_AND_HRS: t_blank = weekday && in_window;
            dbc_pkg::DAY_ALWAYS:        t_blank = 1'b1;
            default:                    t_blank = 1'b0;
        endcase

        if (cfg.motion_mode == dbc_pkg::MM_TIME_ONLY)
            blank = t_blank;
        else if (cfg.motion_mode == dbc_pkg::MM_TIME_OR_MOTION)
            blank = t_blank || m_blank;
        else
            blank = sensor_seen ? m_blank : t_blank;

        for (int i = 0; i < dbc_pkg::NUM_OUTPUTS; i++)
        begin
            act = blank ? cfg.output_actions[2*i +: 2] : dbc_pkg::ACT_NORMAL;
            if (act == dbc_pkg::ACT_RESERVED)
                act = dbc_pkg::ACT_BLANK;
            if (i == dbc_pkg::ACT_IDX_LEDS && u.led_override)
                act = dbc_pkg::ACT_BLANK;
            r.actions[i] = act;
            r.changed_mask[i] = act != prev_actions[i];
            prev_actions[i] = act;
        end

        r.blanked = blank;
        r.time_blank = t_blank;
        r.motion_blank = m_blank;
        r.sensor_present = sensor_seen;
        r.progress_permille = progress;
        expected_q.push_back(r);

        if (blank)
            n_blanked++;
        if (m_blank)
            n_motion_blank++;
        if (progress == dbc_pkg::PROGRESS_MAX)
            n_saturated++;
        n_changes += $countones(r.changed_mask);
    endfunction

    task report(string what);
        if (mismatches < 64)
            $display("%0t ERROR %s", $time, what);
        mismatches++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("result %0d %s: got %0h, expected %0h",
                             results_checked, name, got, want));
    endtask

    task check_result(result_t got);
        string act_names [dbc_pkg::NUM_OUTPUTS];
        result_t want;

        act_names = '{"tubes_action", "leds_action", "neons_action",
                      "slave_action", "towers_action"};
        if (expected_q.size() == 0)
        begin
            report("result beat with no update outstanding");
            return;
        end
        want = expected_q.pop_front();
        results_checked++;
        check_field("blanked", 32'(got.blanked), 32'(want.blanked));
        check_field("time_blank", 32'(got.time_blank), 32'(want.time_blank));
        check_field("motion_blank", 32'(got.motion_blank), 32'(want.motion_blank));
        check_field("sensor_present", 32'(got.sensor_present), 32'(want.sensor_present));
        for (int i = 0; i < dbc_pkg::NUM_OUTPUTS; i++)
            check_field(act_names[i], 32'(got.actions[i]), 32'(want.actions[i]));
        check_field("changed_mask", 32'(got.changed_mask), 32'(want.changed_mask));
        check_field("progress_permille", 32'(got.progress_permille),
                    32'(want.progress_permille));
    endtask
endclass

module display_blanking_controller_tb;

    // The limit allows for every beat meeting the longest sender gap, the
    // longest receiver stall and the slowest divide, several times over.
    localparam longint unsigned RUN_LIMIT_NS = 64'd30_000_000;

    localparam int PHASES           = 16;
    localparam int ITEMS_PER_PHASE  = 96;
    localparam int LONG_HOLD_AFTER  = 350;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 60;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [dbc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [dbc_pkg::CFG_DATA_W-1:0]  cfg_data;

    dbc_in_if  in_ch ();
    dbc_out_if out_ch ();

    display_blanking_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    blank_scoreboard sb = new();

    // Stimulus state: a running wall clock in ms, the motion density of the
    // current phase and the number of register settings applied.
    logic [31:0] wall_ms;
    int motion_pct;
    int settings_applied;

    // When set, the sender or the receiver draws no random idle cycles.
    bit calm_in;
    bit calm_out;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Result side. The receiver decides ready at each falling edge, with
    // mostly short stalls and a few long ones. Once, after a fixed number of
    // results, it holds off for a long stretch counted here, so that the
    // result register fills and the block stops taking update beats.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        int r;
        bit hold_done;

        out_ch.ready = 1'b0;
        stall_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sb.results_checked >= LONG_HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ch.ready = 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready = 1'b1;
                if (!calm_out)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 65)
                        stall_left = 0;
                    else if (r < 95)
                        stall_left = $urandom_range(1, 3);
                    else
                        stall_left = $urandom_range(15, 60);
                end
            end
        end
    end

    // Every result beat is taken at the rising edge at which it is accepted
    // and handed to the scoreboard.
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.blanked           = out_ch.blanked;
            got.time_blank        = out_ch.time_blank;
            got.motion_blank      = out_ch.motion_blank;
            got.sensor_present    = out_ch.sensor_present;
            got.actions[0]        = out_ch.tubes_action;
            got.actions[1]        = out_ch.leds_action;
            got.actions[2]        = out_ch.neons_action;
            got.actions[3]        = out_ch.slave_action;
            got.actions[4]        = out_ch.towers_action;
            got.changed_mask      = out_ch.changed_mask;
            got.progress_permille = out_ch.progress_permille;
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Update side.
    // ------------------------------------------------------------------------

    // Mostly back-to-back or short gaps, now and then a long one.
    function int pick_gap();
        int r;
        if (calm_in)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offers one update beat after a random gap and waits for it to be taken.
    // Valid is left high after acceptance; whatever follows starts at the
    // next falling edge, before the block can see it again.
    task offer_update(input update_t u);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid = 1'b0;
        end
        @(negedge clk);
        in_ch.valid        = 1'b1;
        in_ch.motion_level = u.motion_level;
        in_ch.now_ms       = u.now_ms;
        in_ch.day_of_week  = u.day_of_week;
        in_ch.hour_of_day  = u.hour_of_day;
        in_ch.led_override = u.led_override;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sb.note_update(u);
    endtask

    task offer_fields(input logic motion, input logic [31:0] now, input logic [2:0] dow,
                      input logic [4:0] hour, input logic led);
        update_t u;
        u.motion_level = motion;
        u.now_ms       = now;
        u.day_of_week  = dow;
        u.hour_of_day  = hour;
        u.led_override = led;
        offer_update(u);
    endtask

    // Stops offering and waits until every expected result beat has come.
    task drain_results();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task write_register(input logic [dbc_pkg::CFG_INDEX_W-1:0] idx,
                        input logic [dbc_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Optionally fills the unused upper bits of a register write with noise,
    // which the block must ignore.
    function logic [dbc_pkg::CFG_DATA_W-1:0] pad_field(
        logic [dbc_pkg::CFG_DATA_W-1:0] value, int width, bit dirty);
        logic [31:0] keep;
        logic [dbc_pkg::CFG_DATA_W-1:0] noise;
        keep = (32'h1 << width) - 32'h1;
        noise = 16'($urandom);
        if (!dirty)
            return value;
        return (noise & ~keep[dbc_pkg::CFG_DATA_W-1:0]) |
               (value & keep[dbc_pkg::CFG_DATA_W-1:0]);
    endfunction

    // Registers change only with the block idle, once every result is in.
    task apply_config(input blank_cfg_t c, input bit dirty);
        drain_results();
        repeat (4) @(posedge clk);
        write_register(dbc_pkg::CFG_DAY_MODE, pad_field(16'(c.day_mode), 4, dirty));
        write_register(dbc_pkg::CFG_HOUR_START, pad_field(16'(c.hour_start), 5, dirty));
        write_register(dbc_pkg::CFG_HOUR_END, pad_field(16'(c.hour_end), 5, dirty));
        write_register(dbc_pkg::CFG_MOTION_TIMEOUT, c.motion_timeout_s);
        write_register(dbc_pkg::CFG_MOTION_MODE, pad_field(16'(c.motion_mode), 2, dirty));
        write_register(dbc_pkg::CFG_OUTPUT_ACTIONS,
                       pad_field(16'(c.output_actions), 10, dirty));
        settings_applied++;
    endtask

    // Most updates follow a plausible clock ticking about once a second, so
    // the motion timeout is reached and passed; the rest jump anywhere or
    // land just short of the 32-bit wrap.
    function update_t random_update();
        update_t u;
        int r;
        logic [31:0] step;

        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            wall_ms = $urandom;
        end
        else if (r < 12)
        begin
            wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 4000);
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                step = $urandom_range(900, 1100);
            else if (r < 85)
                step = $urandom_range(0, 999);
            else
                step = $urandom_range(1000, 20000);
            wall_ms = wall_ms + step;
        end
        u.now_ms       = wall_ms;
        u.motion_level = $urandom_range(0, 99) < motion_pct;
        u.day_of_week  = ($urandom_range(0, 19) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
        u.hour_of_day  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                                     : 5'($urandom_range(0, 23));
        u.led_override = $urandom_range(0, 9) == 0;
        return u;
    endfunction

    // Register setting of one random phase. The first phase has every
    // register at zero and the last every register at its top value; the
    // day mode steps through all sixteen codes and the motion mode through
    // all four.
    function blank_cfg_t phase_config(int phase);
        blank_cfg_t c;
        int r;
        if (phase == 0)
            return '0;
        if (phase == PHASES - 1)
            return '1;
        c.day_mode = phase[3:0];
        c.motion_mode = phase[1:0];
        c.hour_start = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                                   : 5'($urandom_range(0, 23));
        c.hour_end = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                                 : 5'($urandom_range(0, 23));
        r = $urandom_range(0, 99);
        if (r < 70)
            c.motion_timeout_s = 16'($urandom_range(0, 12));
        else if (r < 85)
            c.motion_timeout_s = 16'($urandom_range(13, 600));
        else
            c.motion_timeout_s = 16'($urandom_range(0, 65535));
        c.output_actions = 10'($urandom_range(0, 1023));
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        blank_cfg_t c;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.motion_level = 1'b0;
        in_ch.now_ms = '0;
        in_ch.day_of_week = dbc_pkg::DOW_SUNDAY;
        in_ch.hour_of_day = '0;
        in_ch.led_override = 1'b0;
        wall_ms = '0;
        motion_pct = 30;
        settings_applied = 0;
        calm_in = 1'b0;
        calm_out = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset setting: never blank by time, 300 s timeout, sensor ignored.
        // Motion first, then no motion within the first second, then exactly
        // on the timeout and one millisecond past it.
        offer_fields(1'b1, 32'd0, dbc_pkg::DOW_SUNDAY, 5'd0, 1'b0);
        offer_fields(1'b0, 32'd500, dbc_pkg::DOW_SATURDAY, 5'd23, 1'b1);
        offer_fields(1'b0, 32'd300_000, 3'd3, 5'd12, 1'b0);
        offer_fields(1'b0, 32'd300_001, 3'd3, 5'd12, 1'b0);

        // Always blank, time or motion, zero timeout, every action coded with
        // the unused value. Full progress with a zero timeout, then elapsed
        // time across the wrap of the millisecond clock.
        c = '0;
        c.day_mode = dbc_pkg::DAY_ALWAYS;
        c.hour_start = 5'd22;
        c.hour_end = 5'd6;
        c.motion_timeout_s = 16'd0;
        c.motion_mode = dbc_pkg::MM_TIME_OR_MOTION;
        c.output_actions = 10'h3FF;
        apply_config(c, 1'b0);
        offer_fields(1'b0, 32'hFFFF_FFFF, dbc_pkg::DOW_SATURDAY, 5'd23, 1'b0);
        offer_fields(1'b1, 32'hFFFF_FC18, dbc_pkg::DOW_SATURDAY, 5'd23, 1'b0);
        offer_fields(1'b0, 32'h0000_0400, dbc_pkg::DOW_SUNDAY, 5'd0, 1'b1);

        // Hour window that wraps past midnight, with dim actions.
        c.day_mode = dbc_pkg::DAY_HOURS;
        c.motion_timeout_s = 16'd1;
        c.motion_mode = dbc_pkg::MM_TIME_ONLY;
        c.output_actions = 10'h155;
        apply_config(c, 1'b0);
        offer_fields(1'b1, 32'd10_000, 3'd2, 5'd21, 1'b0);
        offer_fields(1'b1, 32'd11_000, 3'd2, 5'd22, 1'b0);
        offer_fields(1'b1, 32'd12_000, 3'd2, 5'd5, 1'b0);
        offer_fields(1'b1, 32'd13_000, 3'd2, 5'd6, 1'b0);

        // Start equal to end blanks that single hour only.
        c.hour_start = 5'd9;
        c.hour_end = 5'd9;
        c.output_actions = 10'h2A6;
        apply_config(c, 1'b0);
        offer_fields(1'b1, 32'd14_000, 3'd4, 5'd9, 1'b0);
        offer_fields(1'b1, 32'd15_000, 3'd4, 5'd10, 1'b0);

        // Plain window, both edges on either side.
        c.hour_start = 5'd3;
        c.hour_end = 5'd8;
        apply_config(c, 1'b0);
        offer_fields(1'b1, 32'd16_000, 3'd5, 5'd2, 1'b0);
        offer_fields(1'b1, 32'd17_000, 3'd5, 5'd3, 1'b0);
        offer_fields(1'b1, 32'd18_000, 3'd5, 5'd7, 1'b0);
        offer_fields(1'b1, 32'd19_000, 3'd5, 5'd8, 1'b0);

        // Weekday and hours: a weekday of zero is neither weekday nor weekend.
        c.day_mode = dbc_pkg::DAY_WKDAY_AND_HRS;
        apply_config(c, 1'b0);
        offer_fields(1'b1, 32'd20_000, 3'd0, 5'd4, 1'b0);
        offer_fields(1'b1, 32'd21_000, 3'd2, 5'd4, 1'b0);
        offer_fields(1'b1, 32'd22_000, 3'd6, 5'd4, 1'b0);
        offer_fields(1'b1, 32'd23_000, dbc_pkg::DOW_SATURDAY, 5'd4, 1'b0);

        // Unused day mode and unused motion mode; a one-second timeout with
        // a long silence drives the progress into saturation.
        c.day_mode = 4'd15;
        c.motion_mode = 2'd3;
        apply_config(c, 1'b0);
        offer_fields(1'b0, 32'd123_000, 3'd3, 5'd4, 1'b0);

        // Random phases, one register setting each.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            apply_config(phase_config(phase), phase[0]);
            motion_pct = (phase == 4) ? 0 : $urandom_range(5, 50);
            calm_in = (phase % 5 == 2) || (phase % 7 == 6);
            calm_out = (phase % 5 == 3) || (phase % 7 == 6);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Now and then the sender waits for every result first.
                if ((phase == 8 && i == ITEMS_PER_PHASE / 2) || $urandom_range(0, 199) == 0)
                    drain_results();
                offer_update(random_update());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        $display("summary: %0d updates and %0d results over %0d register settings",
                 sb.updates_noted, sb.results_checked, settings_applied);
        $display("summary: %0d blanked, %0d motion timeouts, %0d saturated, %0d changes",
                 sb.n_blanked, sb.n_motion_blank, sb.n_saturated, sb.n_changes);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog in case a handshake never completes.
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("%0t ERROR run limit reached with %0d results outstanding",
                 $time, sb.pending());
        $display("status: fail");
        $finish;
    end

endmodule
